>>> hdl/plut_pkg.sv
`timescale 1ns / 1ps
// Package for the palette lookup with team remap.
// Word types, op and scheme codes, gradient colour tables and channel helpers.
package plut_pkg;

    localparam int unsigned ENTRIES   = 256;
    localparam int unsigned ENTRY_W   = 24;
    localparam int unsigned STEPS     = 16;
    localparam int unsigned SCHEMES   = 3;
    localparam int unsigned CHANNELS  = 3;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_LOOKUP = 1'b1;

    localparam logic [1:0] SCHEME_RED     = 2'd0;
    localparam logic [1:0] SCHEME_BLUE    = 2'd1;
    localparam logic [1:0] SCHEME_NEUTRAL = 2'd2;
    localparam logic [1:0] SCHEME_SPARE   = 2'd3;

    localparam logic [3:0] REMAP_BASE = 4'h1;
    localparam logic [5:0] VGA_MAX    = 6'd63;
    localparam logic [12:0] RECIP_15  = 13'd4370;

    localparam logic [7:0] DARK_TAB [SCHEMES][CHANNELS] = '{
        '{8'd48, 8'd4,  8'd3},
        '{8'd4,  8'd20, 8'd58},
        '{8'd32, 8'd32, 8'd32}
    };
    localparam logic [7:0] BRIGHT_TAB [SCHEMES][CHANNELS] = '{
        '{8'd255, 8'd64,  8'd30},
        '{8'd70,  8'd170, 8'd255},
        '{8'd210, 8'd210, 8'd210}
    };

    typedef struct packed {
        logic       op;
        logic [7:0] entry_index;
        logic [7:0] raw_red;
        logic [7:0] raw_green;
        logic [7:0] raw_blue;
        logic [1:0] team_scheme;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_word_t;

    // clamp to 63, then v*255/63 = 4v + v/21
    function automatic logic [7:0] expand_chan(input logic [7:0] raw);
        logic [5:0] v;
        logic [1:0] q;
        v = (raw > 8'(VGA_MAX)) ? VGA_MAX : raw[5:0];
        if (v >= 6'd63) begin
            q = 2'd3;
        end else if (v >= 6'd42) begin
            q = 2'd2;
        end else if (v >= 6'd21) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        return {v, 2'b00} + 8'(q);
    endfunction

    // dark + floor((bright-dark)*k/15), divide by reciprocal
    function automatic logic [7:0] grad_chan(input logic [7:0] dark, input logic [7:0] bright,
                                             input logic [3:0] k);
        logic [11:0] prod;
        logic [24:0] scaled;
        prod   = 12'(bright - dark) * 12'(k);
        scaled = 25'(prod) * 25'(RECIP_15);
        return dark + scaled[23:16];
    endfunction

endpackage

>>> hdl/palette_lookup_with_team_remap.sv
`timescale 1ns / 1ps
// Palette lookup with team remap: top level, palette RAM, entry valid bits, output stage.
// Depends on plut_pkg, plut_ram and plut_grad.
//
//  channel | ports                     | word
//  --------+---------------------------+--------------------------------
//  input   | s_valid, s_ready, s_data  | plut_pkg::in_word_t
//  result  | m_valid, m_ready, m_data  | plut_pkg::out_word_t (lookups)
//
// One word per cycle while s_ready is high; a lookup result passes two registers after
// acceptance (palette RAM read register, then output register). Writes give no result.
// Reset clears the per-entry valid bits at once, so every entry outside the remap range 16 to 31 reads zero.
// A stalled result holds the output register, then the read stage, then s_ready.
module palette_lookup_with_team_remap (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plut_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output plut_pkg::out_word_t m_data
);

    logic                      accept;
    logic                      is_lookup;
    logic                      ram_we;
    logic                      ram_re;
    logic [23:0]               ram_wdata;
    logic [23:0]               ram_rdata;
    logic [23:0]               grad_colour;
    logic                      p1_adv;
    logic [23:0]               p1_colour;

    logic [plut_pkg::ENTRIES-1:0] live_reg;
    logic                      p1_valid_reg, p1_valid_next;
    logic                      p1_remap_reg;
    logic                      p1_live_reg;
    logic [23:0]               p1_grad_reg;
    logic                      m_valid_reg, m_valid_next;
    plut_pkg::out_word_t       m_data_reg;

    assign accept    = s_valid & s_ready;
    assign is_lookup = (s_data.op == plut_pkg::OP_LOOKUP);
    assign ram_we    = accept & ~is_lookup;
    assign ram_re    = accept & is_lookup;
    assign ram_wdata = {plut_pkg::expand_chan(s_data.raw_red),
                        plut_pkg::expand_chan(s_data.raw_green),
                        plut_pkg::expand_chan(s_data.raw_blue)};

    plut_ram #(
        .DATA_W (plut_pkg::ENTRY_W),
        .DEPTH  (plut_pkg::ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (s_data.entry_index),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    plut_grad u_grad (
        .scheme (s_data.team_scheme),
        .step   (s_data.entry_index[3:0]),
        .colour (grad_colour)
    );

    assign p1_adv  = p1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~p1_valid_reg | p1_adv;

    always_comb begin
        if (p1_remap_reg) begin
            p1_colour = p1_grad_reg;
        end else if (p1_live_reg) begin
            p1_colour = ram_rdata;
        end else begin
            p1_colour = '0;
        end
    end

    always_comb begin
        if (ram_re) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg     <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (ram_we) begin
                live_reg[s_data.entry_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            p1_remap_reg <= (s_data.entry_index[7:4] == plut_pkg::REMAP_BASE);
            p1_live_reg  <= live_reg[s_data.entry_index];
            p1_grad_reg  <= grad_colour;
        end
        if (p1_adv) begin
            m_data_reg <= p1_colour;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/plut_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// Stand-alone; no package dependency.
module plut_ram #(
    parameter int unsigned DATA_W = 24,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/plut_grad.sv
`timescale 1ns / 1ps
// Team gradient colour table: scheme and step to a 24-bit RGB colour.
// Depends on plut_pkg for the dark and bright tables and the gradient helper.
module plut_grad (
    input  logic [1:0]  scheme,
    input  logic [3:0]  step,
    output logic [23:0] colour
);

    logic [23:0] lut [plut_pkg::SCHEMES][plut_pkg::STEPS];
    logic [1:0]  row;

    for (genvar s = 0; s < plut_pkg::SCHEMES; s++) begin : g_scheme
        for (genvar k = 0; k < plut_pkg::STEPS; k++) begin : g_step
            assign lut[s][k] = {
                plut_pkg::grad_chan(plut_pkg::DARK_TAB[s][0], plut_pkg::BRIGHT_TAB[s][0], 4'(k)),
                plut_pkg::grad_chan(plut_pkg::DARK_TAB[s][1], plut_pkg::BRIGHT_TAB[s][1], 4'(k)),
                plut_pkg::grad_chan(plut_pkg::DARK_TAB[s][2], plut_pkg::BRIGHT_TAB[s][2], 4'(k))
            };
        end
    end

    always_comb begin
        unique case (scheme) inside
            plut_pkg::SCHEME_RED:                           row = 2'd0;
            plut_pkg::SCHEME_BLUE:                          row = 2'd1;
            plut_pkg::SCHEME_NEUTRAL, plut_pkg::SCHEME_SPARE: row = 2'd2;
            default:                                        row = 2'd2;
        endcase
    end

    assign colour = lut[row][step];

endmodule

>>> tb/colour_lookup_check.sv
`timescale 1ns / 1ps
// Checker for palette_lookup_with_team_remap: keeps its own copy of the palette, predicts
// each lookup colour and compares result words in order. Depends on plut_pkg.
module colour_lookup_check
    import plut_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        colours_due
);

    localparam logic [7:0] REMAP_LO   = 8'd16;
    localparam logic [7:0] REMAP_HI   = 8'd31;
    localparam int         GRAD_STEPS = 15;
    localparam int         RAW_TOP    = 63;
    localparam int         FULL_SCALE = 255;

    localparam logic [7:0] GRAD_DARK [3][3] = '{
        '{8'd48, 8'd4, 8'd3}, '{8'd4, 8'd20, 8'd58}, '{8'd32, 8'd32, 8'd32}
    };
    localparam logic [7:0] GRAD_BRIGHT [3][3] = '{
        '{8'd255, 8'd64, 8'd30}, '{8'd70, 8'd170, 8'd255}, '{8'd210, 8'd210, 8'd210}
    };

    logic [23:0] palette_copy [256];
    out_word_t   colour_queue [$];
    out_word_t   due;
    int          fails = 0;

    function automatic logic [7:0] expand_vga(input logic [7:0] raw);
        int v;
        v = (int'(raw) > RAW_TOP) ? RAW_TOP : int'(raw);
        return 8'((v * FULL_SCALE) / RAW_TOP);
    endfunction

    function automatic logic [7:0] grad_step(input logic [7:0] dark, input logic [7:0] bright,
                                             input int k);
        return 8'(int'(dark) + ((int'(bright) - int'(dark)) * k) / GRAD_STEPS);
    endfunction

    function automatic out_word_t predict_colour(input logic [7:0] idx, input logic [1:0] scheme);
        out_word_t c;
        int        s;
        int        k;
        logic [23:0] e;
        if (idx >= REMAP_LO && idx <= REMAP_HI) begin
            s = (scheme == SCHEME_SPARE) ? int'(SCHEME_NEUTRAL) : int'(scheme);
            k = int'(idx - REMAP_LO);
            c.out_red   = grad_step(GRAD_DARK[s][0], GRAD_BRIGHT[s][0], k);
            c.out_green = grad_step(GRAD_DARK[s][1], GRAD_BRIGHT[s][1], k);
            c.out_blue  = grad_step(GRAD_DARK[s][2], GRAD_BRIGHT[s][2], k);
        end else begin
            e = palette_copy[idx];
            c.out_red   = e[23:16];
            c.out_green = e[15:8];
            c.out_blue  = e[7:0];
        end
        return c;
    endfunction

    task automatic check_chan(input string chan, input logic [7:0] exp_v, input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, chan, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) begin
                palette_copy[i] = '0;
            end
            colour_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.op == OP_WRITE) begin
                    palette_copy[s_data.entry_index] = {expand_vga(s_data.raw_red),
                                                        expand_vga(s_data.raw_green),
                                                        expand_vga(s_data.raw_blue)};
                end else begin
                    colour_queue.push_back(predict_colour(s_data.entry_index,
                                                          s_data.team_scheme));
                end
            end
            if (m_valid && m_ready) begin
                if (colour_queue.size() == 0) begin
                    $display("%0t: result word expected none, got %h", $time, m_data);
                    fails++;
                end else begin
                    due = colour_queue.pop_front();
                    check_chan("red",   due.out_red,   m_data.out_red);
                    check_chan("green", due.out_green, m_data.out_green);
                    check_chan("blue",  due.out_blue,  m_data.out_blue);
                end
            end
        end
        fail_count  <= fails;
        colours_due <= colour_queue.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for palette_lookup_with_team_remap: clock, reset, write and lookup
// stimulus with random idling, verdict. Depends on plut_pkg and colour_lookup_check.
module tb;
    import plut_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 1750;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic      calm    = 1'b0;
    int        fail_count;
    int        colours_due;
    int        cycles   = 0;
    int        hold_cnt = 0;
    int        rx_gap;

    palette_lookup_with_team_remap uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    colour_lookup_check checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .colours_due (colours_due)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** palette_lookup_with_team_remap: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // receiver: runs of ready and stalls of random length
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (m_ready) begin
            rx_gap = pick_gap();
            if (rx_gap != 0) begin
                m_ready  <= 1'b0;
                hold_cnt <= rx_gap - 1;
            end else begin
                hold_cnt <= $urandom_range(0, 7);
            end
        end else begin
            m_ready  <= 1'b1;
            hold_cnt <= $urandom_range(0, 7);
        end
    end

    function automatic in_word_t write_word(input logic [7:0] idx, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [1:0] scheme);
        in_word_t w;
        w = '{op: OP_WRITE, entry_index: idx, raw_red: r, raw_green: g, raw_blue: b,
              team_scheme: scheme};
        return w;
    endfunction

    function automatic in_word_t lookup_word(input logic [7:0] idx, input logic [1:0] scheme,
                                             input logic [7:0] raw);
        in_word_t w;
        w = '{op: OP_LOOKUP, entry_index: idx, raw_red: raw, raw_green: raw, raw_blue: raw,
              team_scheme: scheme};
        return w;
    endfunction

    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return 8'($urandom_range(16, 31));
        end else if (r == 3) begin
            case ($urandom_range(0, 5))
                0: return 8'd15;
                1: return 8'd16;
                2: return 8'd31;
                3: return 8'd32;
                4: return 8'd0;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_raw();
        case ($urandom_range(0, 3))
            0, 1: return 8'($urandom_range(0, 63));
            2: return 8'($urandom_range(0, 255));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd63;
                    2: return 8'd64;
                    default: return 8'd255;
                endcase
            end
        endcase
    endfunction

    // hold the word until accepted, then idle for a random gap (none while calm)
    task automatic send_word(input in_word_t w);
        int g;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain_colours();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colours_due != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(lookup_word(8'd0,   SCHEME_RED,  8'h00));
        send_word(lookup_word(8'd255, SCHEME_BLUE, 8'hFF));
        send_word(write_word(8'd0,   8'd0,   8'd0,   8'd0,   SCHEME_RED));
        send_word(write_word(8'd255, 8'd255, 8'd255, 8'd255, SCHEME_BLUE));
        send_word(write_word(8'd1,   8'd63,  8'd62,  8'd21,  SCHEME_NEUTRAL));
        send_word(write_word(8'd2,   8'd64,  8'd20,  8'd42,  SCHEME_RED));
        send_word(write_word(8'd16,  8'd10,  8'd10,  8'd10,  SCHEME_RED));
        send_word(write_word(8'd200, 8'd33,  8'd128, 8'd7,   SCHEME_SPARE));
        send_word(lookup_word(8'd0,   SCHEME_RED,     8'h00));
        send_word(lookup_word(8'd255, SCHEME_RED,     8'h00));
        send_word(lookup_word(8'd1,   SCHEME_NEUTRAL, 8'h00));
        send_word(lookup_word(8'd2,   SCHEME_BLUE,    8'h00));
        send_word(lookup_word(8'd200, SCHEME_RED,     8'hFF));
        send_word(lookup_word(8'd16,  SCHEME_RED,     8'h00));
        send_word(lookup_word(8'd16,  SCHEME_BLUE,    8'h00));
        send_word(lookup_word(8'd16,  SCHEME_NEUTRAL, 8'h00));
        send_word(lookup_word(8'd16,  SCHEME_SPARE,   8'h00));
        send_word(lookup_word(8'd31,  SCHEME_RED,     8'h00));
        send_word(lookup_word(8'd31,  SCHEME_BLUE,    8'h00));
        send_word(lookup_word(8'd31,  SCHEME_NEUTRAL, 8'h00));
        send_word(lookup_word(8'd31,  SCHEME_SPARE,   8'h00));
        send_word(lookup_word(8'd15,  SCHEME_BLUE,    8'h00));
        send_word(lookup_word(8'd32,  SCHEME_BLUE,    8'h00));
        drain_colours();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm <= ((i % 400) >= 300);
            if (i == RANDOM_WORDS / 2) begin
                drain_colours();
            end
            if ($urandom_range(0, 99) < 45) begin
                send_word(write_word(pick_index(), pick_raw(), pick_raw(), pick_raw(),
                                     2'($urandom_range(0, 3))));
            end else begin
                send_word(lookup_word(pick_index(), 2'($urandom_range(0, 3)),
                                      8'($urandom_range(0, 255))));
            end
        end
        calm <= 1'b0;

        drain_colours();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** palette_lookup_with_team_remap: PASSED **");
        end else begin
            $display("** palette_lookup_with_team_remap: FAILED **");
        end
        $finish;
    end

endmodule

>>> palette_lookup_with_team_remap.f
hdl/plut_pkg.sv
hdl/plut_ram.sv
hdl/plut_grad.sv
hdl/palette_lookup_with_team_remap.sv
tb/colour_lookup_check.sv
tb/tb.sv
